FILE: hdl/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared types, constants and helpers of the braille dot plot engine.
// ----------------------------------------------------------------------------
package bdp_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_COLS  = (MAX_WIDTH + 1) / 2;
	localparam int STORE_ROWS  = (MAX_HEIGHT + 3) / 4;
	localparam int COL_W       = $clog2(STORE_COLS);
	localparam int ROW_W       = $clog2(STORE_ROWS);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int DEPTH       = STORE_COLS * STORE_ROWS;
	localparam int WALK_LIMIT  = 4096;
	localparam int STEP_W      = $clog2(WALK_LIMIT) + 1;

	// dot bit per (row within cell, column within cell)
	localparam logic [7:0] DOT_BIT [4][2] = '{
		'{8'b00000001, 8'b00001000},
		'{8'b00000010, 8'b00010000},
		'{8'b00000100, 8'b00100000},
		'{8'b01000000, 8'b10000000}};

	typedef logic signed [13:0] coord_t;
	typedef logic signed [39:0] err_t;

	typedef enum logic [2:0] {
		CMD_DOT_ON   = 3'd0,
		CMD_DOT_OFF  = 3'd1,
		CMD_TOGGLE   = 3'd2,
		CMD_LINE     = 3'd3,
		CMD_ELLIPSE  = 3'd4,
		CMD_FILLED   = 3'd5,
		CMD_READ     = 3'd6,
		CMD_NOP      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_SET    = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_TOGGLE = 2'd2
	} mode_t;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR, OP_LOAD, OP_SETDOT_A, OP_RD, OP_WR, OP_REJECT,
		OP_LINE_INIT, OP_LINE_DOT, OP_LINE_STEP, OP_LINE_END,
		OP_MUL1, OP_MUL2, OP_INIT3, OP_QDOT, OP_HSPAN0, OP_HSPAN1,
		OP_SPAN_DOT, OP_SPAN_NEXT, OP_STEPA, OP_STEPB, OP_VSTEP, OP_VDOT,
		OP_VSPAN, OP_CELL_RD, OP_CELL_LATCH, OP_RESULT
	} op_t;

	typedef struct packed {
		cmd_t cmd;
		logic line_reject;
		logic line_more;
		logic span_more;
		logic quad_last;
		logic quad_odd;
		logic ell_more;
		logic v_more;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

	function automatic logic dot_inside(coord_t x, coord_t y, logic [8:0] w, logic [8:0] h);
		return (x >= 0) && (y >= 0) && (x < $signed({5'b0, w})) && (y < $signed({5'b0, h}));
	endfunction

endpackage

FILE: hdl/bdp_datapath.sv
// ----------------------------------------------------------------------------
// bdp_datapath
// Dot store, walk registers and arithmetic, driven one operation a cycle.
// ----------------------------------------------------------------------------
module bdp_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  bdp_pkg::op_t        op,
	input  logic [8:0]          eff_w,
	input  logic [8:0]          eff_h,
	input  logic [2:0]          cmd,
	input  logic signed [10:0]  x_a,
	input  logic signed [10:0]  y_a,
	input  logic signed [10:0]  x_b,
	input  logic signed [10:0]  y_b,
	input  logic [8:0]          radius_x,
	input  logic [8:0]          radius_y,
	input  logic [6:0]          cell_col,
	input  logic [5:0]          cell_row,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [7:0]          cell_dots,
	output logic                status,
	output bdp_pkg::dp_stat_t   stat
);

	logic [7:0] mem [bdp_pkg::DEPTH];
	logic [7:0] rdata_q;
	logic                       mem_we, mem_re;
	logic [bdp_pkg::ADDR_W-1:0] mem_waddr, mem_raddr, dot_addr, clr_q;
	logic [7:0]                 mem_wdata, bit_sel;

	bdp_pkg::cmd_t   cmd_q;
	bdp_pkg::coord_t xa_q, ya_q, xb_q, yb_q, wx_q, wy_q, dot_x_q, dot_y_q;
	bdp_pkg::coord_t span_pos_q, span_hi_q, span_fix_q;
	logic            span_axis_q;
	logic [8:0]      rx_q, ry_q;
	logic [6:0]      col_q;
	logic [5:0]      row_q;
	logic [17:0]     area_q, rr1_q, rr2_q;
	bdp_pkg::err_t   err_q, stepx_q, stepy_q;
	logic            condy_q;
	logic [bdp_pkg::STEP_W-1:0] steps_q;
	logic [1:0]      quad_q;
	bdp_pkg::mode_t  mode_q;
	logic            dot_in_q;
	logic [7:0]      dots_q, m_dots_q;
	logic            stat_q, m_valid_q, m_stat_q;

	// line terms
	bdp_pkg::coord_t ddx, ddy;
	logic [11:0]     dx, dy, len;
	bdp_pkg::err_t   l_err1, l_err2;
	logic            l_c1, l_c2;
	// ellipse terms
	logic signed [11:0] one_m;
	logic signed [30:0] sx_prod;
	bdp_pkg::err_t      e2, stepx_n, stepy_n;
	// span terms
	bdp_pkg::coord_t cx_p, cx_m, cy_p, cy_m, hs_lo, hs_hi, vs_lo, vs_hi, w_m1, h_m1;
	bdp_pkg::coord_t q_x, q_y;
	logic            cell_ok;

	assign ddx = xb_q - xa_q;
	assign ddy = yb_q - ya_q;
	assign dx  = ddx[13] ? 12'(-ddx) : 12'(ddx);
	assign dy  = ddy[13] ? 12'(-ddy) : 12'(ddy);
	assign len = (dx > dy) ? dx : dy;

	assign l_c1   = (err_q <<< 1) >= -bdp_pkg::err_t'({1'b0, dy});
	assign l_err1 = l_c1 ? err_q - bdp_pkg::err_t'({1'b0, dy}) : err_q;
	assign l_c2   = (l_err1 <<< 1) <= bdp_pkg::err_t'({1'b0, dx});
	assign l_err2 = l_c2 ? l_err1 + bdp_pkg::err_t'({1'b0, dx}) : l_err1;

	assign one_m   = 12'sd1 - $signed({2'b0, rx_q, 1'b0});
	assign sx_prod = 31'(one_m) * 31'($signed({1'b0, rr2_q}));
	assign e2      = err_q <<< 1;
	assign stepx_n = stepx_q + bdp_pkg::err_t'({rr2_q, 1'b0});
	assign stepy_n = stepy_q + bdp_pkg::err_t'({rr1_q, 1'b0});

	assign cx_p = xa_q + wx_q;
	assign cx_m = xa_q - wx_q;
	assign cy_p = ya_q + wy_q;
	assign cy_m = ya_q - wy_q;
	assign w_m1 = $signed({5'b0, eff_w}) - 14'sd1;
	assign h_m1 = $signed({5'b0, eff_h}) - 14'sd1;
	assign hs_lo = (cx_p < 0) ? '0 : cx_p;
	assign hs_hi = (cx_m > w_m1) ? w_m1 : cx_m;
	assign vs_lo = (cy_m < 0) ? '0 : cy_m;
	assign vs_hi = (cy_p > h_m1) ? h_m1 : cy_p;

	always_comb begin
		case (quad_q)
			2'd0: begin q_x = cx_m; q_y = cy_p; end
			2'd1: begin q_x = cx_p; q_y = cy_p; end
			2'd2: begin q_x = cx_p; q_y = cy_m; end
			default: begin q_x = cx_m; q_y = cy_m; end
		endcase
	end

	assign dot_addr = {dot_y_q[bdp_pkg::ROW_W+1:2], dot_x_q[bdp_pkg::COL_W:1]};
	assign bit_sel  = bdp_pkg::DOT_BIT[dot_y_q[1:0]][dot_x_q[0]];
	assign cell_ok  = ({1'b0, col_q} < 8'(bdp_pkg::STORE_COLS))
		&& ({1'b0, row_q} < 7'(bdp_pkg::STORE_ROWS));

	always_comb begin
		case (mode_q)
			bdp_pkg::MODE_CLEAR:  mem_wdata = rdata_q & ~bit_sel;
			bdp_pkg::MODE_TOGGLE: mem_wdata = rdata_q ^ bit_sel;
			default:              mem_wdata = rdata_q | bit_sel;
		endcase
		if (op == bdp_pkg::OP_CLR) mem_wdata = '0;
	end

	assign mem_we    = (op == bdp_pkg::OP_CLR) || ((op == bdp_pkg::OP_WR) && dot_in_q);
	assign mem_waddr = (op == bdp_pkg::OP_CLR) ? clr_q : dot_addr;
	assign mem_re    = (op == bdp_pkg::OP_RD) || (op == bdp_pkg::OP_CELL_RD);
	assign mem_raddr = (op == bdp_pkg::OP_CELL_RD)
		? {row_q[bdp_pkg::ROW_W-1:0], col_q[bdp_pkg::COL_W-1:0]} : dot_addr;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			quad_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (op == bdp_pkg::OP_CLR) clr_q <= clr_q + 1'b1;
			case (op)
				bdp_pkg::OP_MUL2, bdp_pkg::OP_VSTEP: quad_q <= '0;
				bdp_pkg::OP_QDOT, bdp_pkg::OP_VDOT:  quad_q <= quad_q + 1'b1;
				default: ;
			endcase
			if (op == bdp_pkg::OP_RESULT) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (op)
			bdp_pkg::OP_LOAD: begin
				cmd_q  <= bdp_pkg::cmd_t'(cmd);
				xa_q   <= bdp_pkg::coord_t'(x_a);
				ya_q   <= bdp_pkg::coord_t'(y_a);
				xb_q   <= bdp_pkg::coord_t'(x_b);
				yb_q   <= bdp_pkg::coord_t'(y_b);
				rx_q   <= radius_x;
				ry_q   <= radius_y;
				col_q  <= cell_col;
				row_q  <= cell_row;
				area_q <= 18'(eff_w) * 18'(eff_h);
				dots_q <= '0;
				stat_q <= 1'b0;
			end
			bdp_pkg::OP_SETDOT_A: begin
				dot_x_q <= xa_q;
				dot_y_q <= ya_q;
				case (cmd_q)
					bdp_pkg::CMD_DOT_OFF: mode_q <= bdp_pkg::MODE_CLEAR;
					bdp_pkg::CMD_TOGGLE:  mode_q <= bdp_pkg::MODE_TOGGLE;
					default:              mode_q <= bdp_pkg::MODE_SET;
				endcase
			end
			bdp_pkg::OP_RD: dot_in_q <= bdp_pkg::dot_inside(dot_x_q, dot_y_q, eff_w, eff_h);
			bdp_pkg::OP_REJECT: stat_q <= 1'b1;
			bdp_pkg::OP_LINE_INIT: begin
				wx_q    <= xa_q;
				wy_q    <= ya_q;
				err_q   <= bdp_pkg::err_t'({1'b0, dx}) - bdp_pkg::err_t'({1'b0, dy});
				steps_q <= '0;
				mode_q  <= bdp_pkg::MODE_SET;
			end
			bdp_pkg::OP_LINE_DOT: begin
				dot_x_q <= wx_q;
				dot_y_q <= wy_q;
			end
			bdp_pkg::OP_LINE_STEP: begin
				err_q   <= l_err2;
				if (l_c1) wx_q <= (xa_q < xb_q) ? wx_q + 14'sd1 : wx_q - 14'sd1;
				if (l_c2) wy_q <= (ya_q < yb_q) ? wy_q + 14'sd1 : wy_q - 14'sd1;
				steps_q <= steps_q + 1'b1;
			end
			bdp_pkg::OP_LINE_END: begin
				dot_x_q <= xb_q;
				dot_y_q <= yb_q;
			end
			bdp_pkg::OP_MUL1: begin
				rr1_q  <= 18'(rx_q) * 18'(rx_q);
				rr2_q  <= 18'(ry_q) * 18'(ry_q);
				mode_q <= bdp_pkg::MODE_SET;
			end
			bdp_pkg::OP_MUL2: begin
				wx_q    <= -bdp_pkg::coord_t'({1'b0, rx_q});
				wy_q    <= '0;
				stepx_q <= bdp_pkg::err_t'(sx_prod);
				stepy_q <= bdp_pkg::err_t'({1'b0, rr1_q});
				steps_q <= '0;
			end
			bdp_pkg::OP_INIT3: err_q <= stepx_q + stepy_q;
			bdp_pkg::OP_QDOT: begin
				dot_x_q <= q_x;
				dot_y_q <= q_y;
			end
			bdp_pkg::OP_HSPAN0, bdp_pkg::OP_HSPAN1: begin
				span_pos_q  <= hs_lo;
				span_hi_q   <= hs_hi;
				span_fix_q  <= (op == bdp_pkg::OP_HSPAN0) ? cy_p : cy_m;
				span_axis_q <= 1'b0;
			end
			bdp_pkg::OP_VSPAN: begin
				span_pos_q  <= vs_lo;
				span_hi_q   <= vs_hi;
				span_fix_q  <= xa_q;
				span_axis_q <= 1'b1;
			end
			bdp_pkg::OP_SPAN_DOT: begin
				dot_x_q <= span_axis_q ? span_fix_q : span_pos_q;
				dot_y_q <= span_axis_q ? span_pos_q : span_fix_q;
			end
			bdp_pkg::OP_SPAN_NEXT: span_pos_q <= span_pos_q + 14'sd1;
			bdp_pkg::OP_STEPA: begin
				condy_q <= e2 <= stepy_q;
				if (e2 >= stepx_q) begin
					wx_q    <= wx_q + 14'sd1;
					stepx_q <= stepx_n;
					err_q   <= err_q + stepx_n;
				end
			end
			bdp_pkg::OP_STEPB: begin
				if (condy_q) begin
					wy_q    <= wy_q + 14'sd1;
					stepy_q <= stepy_n;
					err_q   <= err_q + stepy_n;
				end
				steps_q <= steps_q + 1'b1;
			end
			bdp_pkg::OP_VSTEP: wy_q <= wy_q + 14'sd1;
			bdp_pkg::OP_VDOT: begin
				dot_x_q <= xa_q;
				dot_y_q <= quad_q[0] ? cy_m : cy_p;
			end
			bdp_pkg::OP_CELL_LATCH: dots_q <= cell_ok ? rdata_q : 8'd0;
			bdp_pkg::OP_RESULT: begin
				m_dots_q <= dots_q;
				m_stat_q <= stat_q;
			end
			default: ;
		endcase
	end

	assign stat.cmd         = cmd_q;
	assign stat.line_reject = (!bdp_pkg::dot_inside(xa_q, ya_q, eff_w, eff_h)
		&& !bdp_pkg::dot_inside(xb_q, yb_q, eff_w, eff_h))
		|| ({6'b0, dx, 1'b0} > {1'b0, area_q});
	assign stat.line_more   = {1'b0, steps_q} < {2'b0, len};
	assign stat.span_more   = span_pos_q <= span_hi_q;
	assign stat.quad_last   = quad_q == 2'd3;
	assign stat.quad_odd    = quad_q[0];
	assign stat.ell_more    = (wx_q <= 0) && (steps_q < bdp_pkg::STEP_W'(bdp_pkg::WALK_LIMIT));
	assign stat.v_more      = wy_q < $signed({5'b0, ry_q});
	assign stat.clr_last    = &clr_q;
	assign stat.out_free    = !m_valid_q || m_tready;

	assign m_tvalid  = m_valid_q;
	assign cell_dots = m_dots_q;
	assign status    = m_stat_q;

	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		op == bdp_pkg::OP_RD |=> op == bdp_pkg::OP_WR)
		else $error("dot read not followed by write");
	a_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		op == bdp_pkg::OP_RESULT |-> (!m_valid_q || m_tready))
		else $error("result overwrites pending result");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		op == bdp_pkg::OP_STEPB |-> steps_q < bdp_pkg::STEP_W'(bdp_pkg::WALK_LIMIT))
		else $error("ellipse walk beyond limit");

endmodule

FILE: hdl/bdp_ctrl.sv
// ----------------------------------------------------------------------------
// bdp_ctrl
// Command sequencer: issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
module bdp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  bdp_pkg::dp_stat_t stat,
	output bdp_pkg::op_t      op
);

	typedef enum logic [21:0] {
		ST_CLEAR     = 22'h000001,
		ST_IDLE      = 22'h000002,
		ST_DISPATCH  = 22'h000004,
		ST_RD        = 22'h000008,
		ST_WR        = 22'h000010,
		ST_LINE_CHK  = 22'h000020,
		ST_LINE_STEP = 22'h000040,
		ST_MUL1      = 22'h000080,
		ST_MUL2      = 22'h000100,
		ST_INIT3     = 22'h000200,
		ST_E_BODY    = 22'h000400,
		ST_E_SPAN1   = 22'h000800,
		ST_E_STEPA   = 22'h001000,
		ST_E_STEPB   = 22'h002000,
		ST_E_TEST    = 22'h004000,
		ST_V_TEST    = 22'h008000,
		ST_V_BODY    = 22'h010000,
		ST_SPAN_CHK  = 22'h020000,
		ST_SPAN_NEXT = 22'h040000,
		ST_CELL_RD   = 22'h080000,
		ST_CELL_WAIT = 22'h100000,
		ST_RESULT    = 22'h200000
	} state_t;

	state_t state_q, state_d, ret_q, ret_d, sret_q, sret_d;
	logic   filled;

	assign filled = stat.cmd == bdp_pkg::CMD_FILLED;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		sret_d  = sret_q;
		op      = bdp_pkg::OP_NONE;
		case (state_q)
			ST_CLEAR: begin
				op = bdp_pkg::OP_CLR;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					op      = bdp_pkg::OP_LOAD;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.cmd)
					bdp_pkg::CMD_DOT_ON, bdp_pkg::CMD_DOT_OFF, bdp_pkg::CMD_TOGGLE: begin
						op      = bdp_pkg::OP_SETDOT_A;
						ret_d   = ST_RESULT;
						state_d = ST_RD;
					end
					bdp_pkg::CMD_LINE: begin
						if (stat.line_reject) begin
							op      = bdp_pkg::OP_REJECT;
							state_d = ST_RESULT;
						end else begin
							op      = bdp_pkg::OP_LINE_INIT;
							state_d = ST_LINE_CHK;
						end
					end
					bdp_pkg::CMD_ELLIPSE, bdp_pkg::CMD_FILLED: state_d = ST_MUL1;
					bdp_pkg::CMD_READ: state_d = ST_CELL_RD;
					default: state_d = ST_RESULT;
				endcase
			end
			ST_RD: begin
				op      = bdp_pkg::OP_RD;
				state_d = ST_WR;
			end
			ST_WR: begin
				op      = bdp_pkg::OP_WR;
				state_d = ret_q;
			end
			ST_LINE_CHK: begin
				if (stat.line_more) begin
					op    = bdp_pkg::OP_LINE_DOT;
					ret_d = ST_LINE_STEP;
				end else begin
					op    = bdp_pkg::OP_LINE_END;
					ret_d = ST_RESULT;
				end
				state_d = ST_RD;
			end
			ST_LINE_STEP: begin
				op      = bdp_pkg::OP_LINE_STEP;
				state_d = ST_LINE_CHK;
			end
			ST_MUL1: begin
				op      = bdp_pkg::OP_MUL1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				op      = bdp_pkg::OP_MUL2;
				state_d = ST_INIT3;
			end
			ST_INIT3: begin
				op      = bdp_pkg::OP_INIT3;
				state_d = ST_E_BODY;
			end
			ST_E_BODY: begin
				if (filled) begin
					op      = bdp_pkg::OP_HSPAN0;
					sret_d  = ST_E_SPAN1;
					state_d = ST_SPAN_CHK;
				end else begin
					op      = bdp_pkg::OP_QDOT;
					ret_d   = stat.quad_last ? ST_E_STEPA : ST_E_BODY;
					state_d = ST_RD;
				end
			end
			ST_E_SPAN1: begin
				op      = bdp_pkg::OP_HSPAN1;
				sret_d  = ST_E_STEPA;
				state_d = ST_SPAN_CHK;
			end
			ST_E_STEPA: begin
				op      = bdp_pkg::OP_STEPA;
				state_d = ST_E_STEPB;
			end
			ST_E_STEPB: begin
				op      = bdp_pkg::OP_STEPB;
				state_d = ST_E_TEST;
			end
			ST_E_TEST: state_d = stat.ell_more ? ST_E_BODY : ST_V_TEST;
			ST_V_TEST: begin
				if (stat.v_more) begin
					op      = bdp_pkg::OP_VSTEP;
					state_d = ST_V_BODY;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_V_BODY: begin
				if (filled) begin
					op      = bdp_pkg::OP_VSPAN;
					sret_d  = ST_V_TEST;
					state_d = ST_SPAN_CHK;
				end else begin
					op      = bdp_pkg::OP_VDOT;
					ret_d   = stat.quad_odd ? ST_V_TEST : ST_V_BODY;
					state_d = ST_RD;
				end
			end
			ST_SPAN_CHK: begin
				if (stat.span_more) begin
					op      = bdp_pkg::OP_SPAN_DOT;
					ret_d   = ST_SPAN_NEXT;
					state_d = ST_RD;
				end else begin
					state_d = sret_q;
				end
			end
			ST_SPAN_NEXT: begin
				op      = bdp_pkg::OP_SPAN_NEXT;
				state_d = ST_SPAN_CHK;
			end
			ST_CELL_RD: begin
				op      = bdp_pkg::OP_CELL_RD;
				state_d = ST_CELL_WAIT;
			end
			ST_CELL_WAIT: begin
				op      = bdp_pkg::OP_CELL_LATCH;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					op      = bdp_pkg::OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q   <= ST_RESULT;
			sret_q  <= ST_RESULT;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			sret_q  <= sret_d;
		end
	end

	assign s_tready = state_q == ST_IDLE;

endmodule

FILE: hdl/braille_dot_plot_engine.sv
// ----------------------------------------------------------------------------
// braille_dot_plot_engine
// Braille cell canvas with point, line, ellipse and cell read requests.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered with one result. After reset a
// clearing pass zeroes the 8192-cell store, one cell a cycle, and the input
// stays not ready until it is done (canvas writes are taken meanwhile). Every
// dot is a read-modify-write of the store in three steps: load coordinates,
// read, write. A rejected line is answered with status set. Results wait in
// an output register.
// ----------------------------------------------------------------------------
module braille_dot_plot_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// x_a[10:0] y_a[21:11] x_b[32:22] y_b[43:33] radius_x[52:44]
	// radius_y[61:53] cell_col[68:62] cell_row[74:69], zero fill above
	input  logic [79:0] s_tdata,
	// cmd[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_dots[7:0]
	output logic [7:0]  m_tdata,
	// status[0]
	output logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	logic [8:0] cfg_w_q, cfg_h_q, eff_w, eff_h;
	bdp_pkg::op_t      op;
	bdp_pkg::dp_stat_t stat;
	logic              stat_bit;

	// canvas registers; sizes beyond the store saturate
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= 9'd256;
			cfg_h_q <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				bdp_pkg::CFG_WIDTH:  cfg_w_q <= cfg_data;
				bdp_pkg::CFG_HEIGHT: cfg_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_w = (cfg_w_q > 9'(bdp_pkg::MAX_WIDTH))  ? 9'(bdp_pkg::MAX_WIDTH)  : cfg_w_q;
	assign eff_h = (cfg_h_q > 9'(bdp_pkg::MAX_HEIGHT)) ? 9'(bdp_pkg::MAX_HEIGHT) : cfg_h_q;

	bdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.op       (op)
	);

	bdp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.cmd       (s_tuser),
		.x_a       (s_tdata[10:0]),
		.y_a       (s_tdata[21:11]),
		.x_b       (s_tdata[32:22]),
		.y_b       (s_tdata[43:33]),
		.radius_x  (s_tdata[52:44]),
		.radius_y  (s_tdata[61:53]),
		.cell_col  (s_tdata[68:62]),
		.cell_row  (s_tdata[74:69]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.cell_dots (m_tdata),
		.status    (stat_bit),
		.stat      (stat)
	);

	assign m_tuser = stat_bit;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for braille_dot_plot_engine: a directed table of dot,
// line, ellipse and cell read requests, then random requests over several
// canvas sizes and idling patterns, checked against a local canvas model or typed-in answers.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CYCLE_LIMIT  = 6_000_000;
	localparam int  RAND_PHASES  = 6;
	localparam int  PHASE_ITEMS  = 230;

	typedef struct {
		bdp_pkg::cmd_t cmd;
		int   xa, ya, xb, yb, rx, ry, col, row;
		bit   known;
		logic [7:0] dots;
		logic       status;
	} request_t;

	typedef struct {
		logic [7:0] dots;
		logic       status;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;	// x_a y_a x_b y_b radius_x radius_y cell_col cell_row
	logic [2:0]  s_tuser = '0;	// cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;	// cell_dots
	logic [0:0]  m_tuser;	// status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;

	braille_dot_plot_engine dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// --- canvas model -------------------------------------------------------
	logic [7:0] cells [bdp_pkg::DEPTH];
	logic [8:0] reg_width = 9'd256;
	logic [8:0] reg_height = 9'd256;
	answer_t    pending [$];
	int         errors = 0;
	int         cycles = 0;
	int         src_idle = 0;
	int         snk_stall = 0;

	function automatic int canvas_w();
		return (reg_width > bdp_pkg::MAX_WIDTH) ? bdp_pkg::MAX_WIDTH : int'(reg_width);
	endfunction

	function automatic int canvas_h();
		return (reg_height > bdp_pkg::MAX_HEIGHT) ? bdp_pkg::MAX_HEIGHT : int'(reg_height);
	endfunction

	function automatic bit on_canvas(int x, int y);
		return x >= 0 && y >= 0 && x < canvas_w() && y < canvas_h();
	endfunction

	function automatic void plot(int x, int y, bdp_pkg::mode_t mode);
		int         idx;
		logic [7:0] bit_mask;
		if (!on_canvas(x, y))
			return;
		idx = (y / 4) * bdp_pkg::STORE_COLS + x / 2;
		bit_mask = bdp_pkg::DOT_BIT[y % 4][x % 2];
		case (mode)
			bdp_pkg::MODE_SET:   cells[idx] |= bit_mask;
			bdp_pkg::MODE_CLEAR: cells[idx] &= ~bit_mask;
			default:             cells[idx] ^= bit_mask;
		endcase
	endfunction

	function automatic void row_span(int xa, int xb, int y);
		if (xa < 0) xa = 0;
		if (xb > canvas_w() - 1) xb = canvas_w() - 1;
		for (int x = xa; x <= xb; x++)
			plot(x, y, bdp_pkg::MODE_SET);
	endfunction

	function automatic void col_span(int x, int ya, int yb);
		if (ya < 0) ya = 0;
		if (yb > canvas_h() - 1) yb = canvas_h() - 1;
		for (int y = ya; y <= yb; y++)
			plot(x, y, bdp_pkg::MODE_SET);
	endfunction

	// Bresenham walk; returns 1 when the line is refused
	function automatic logic trace_line(int x1, int y1, int x2, int y2);
		int      dx, dy, sx, sy, len, wx, wy;
		longint  err;
		dx = (x2 > x1) ? x2 - x1 : x1 - x2;
		dy = (y2 > y1) ? y2 - y1 : y1 - y2;
		sx = (x1 < x2) ? 1 : -1;
		sy = (y1 < y2) ? 1 : -1;
		len = (dx > dy) ? dx : dy;
		if (!on_canvas(x1, y1) && !on_canvas(x2, y2))
			return 1'b1;
		if (longint'(dx) * 2 > longint'(canvas_w()) * canvas_h())
			return 1'b1;
		wx = x1;
		wy = y1;
		err = dx - dy;
		for (int i = 0; i < len; i++) begin
			plot(wx, wy, bdp_pkg::MODE_SET);
			if (2 * err >= -longint'(dy)) begin
				err -= dy;
				wx += sx;
			end
			if (2 * err <= longint'(dx)) begin
				err += dx;
				wy += sy;
			end
		end
		plot(x2, y2, bdp_pkg::MODE_SET);
		return 1'b0;
	endfunction

	// midpoint error walk over one quadrant, mirrored four ways
	function automatic void trace_ellipse(int cx, int cy, int r1, int r2, bit filled);
		longint rr1, rr2, e2, err, inc_x, inc_y;
		int     wx, wy, steps;
		rr1 = longint'(r1) * r1;
		rr2 = longint'(r2) * r2;
		wx = -r1;
		wy = 0;
		steps = 0;
		inc_x = (1 - 2 * longint'(r1)) * rr2;
		inc_y = rr1;
		err = inc_x + inc_y;
		do begin
			if (filled) begin
				row_span(cx + wx, cx - wx, cy + wy);
				row_span(cx + wx, cx - wx, cy - wy);
			end else begin
				plot(cx - wx, cy + wy, bdp_pkg::MODE_SET);
				plot(cx + wx, cy + wy, bdp_pkg::MODE_SET);
				plot(cx + wx, cy - wy, bdp_pkg::MODE_SET);
				plot(cx - wx, cy - wy, bdp_pkg::MODE_SET);
			end
			e2 = 2 * err;
			if (e2 >= inc_x) begin
				wx++;
				inc_x += 2 * rr2;
				err += inc_x;
			end
			if (e2 <= inc_y) begin
				wy++;
				inc_y += 2 * rr1;
				err += inc_y;
			end
			steps++;
		end while (wx <= 0 && steps < bdp_pkg::WALK_LIMIT);
		// degenerate flat ellipses leave a vertical tail
		while (wy < r2) begin
			wy++;
			if (filled)
				col_span(cx, cy - wy, cy + wy);
			else begin
				plot(cx, cy + wy, bdp_pkg::MODE_SET);
				plot(cx, cy - wy, bdp_pkg::MODE_SET);
			end
		end
	endfunction

	function automatic answer_t canvas_apply(request_t r);
		answer_t a;
		a.dots = '0;
		a.status = 1'b0;
		case (r.cmd)
			bdp_pkg::CMD_DOT_ON:  plot(r.xa, r.ya, bdp_pkg::MODE_SET);
			bdp_pkg::CMD_DOT_OFF: plot(r.xa, r.ya, bdp_pkg::MODE_CLEAR);
			bdp_pkg::CMD_TOGGLE:  plot(r.xa, r.ya, bdp_pkg::MODE_TOGGLE);
			bdp_pkg::CMD_LINE:    a.status = trace_line(r.xa, r.ya, r.xb, r.yb);
			bdp_pkg::CMD_ELLIPSE: trace_ellipse(r.xa, r.ya, r.rx, r.ry, 1'b0);
			bdp_pkg::CMD_FILLED:  trace_ellipse(r.xa, r.ya, r.rx, r.ry, 1'b1);
			bdp_pkg::CMD_READ:
				if (r.col < bdp_pkg::STORE_COLS && r.row < bdp_pkg::STORE_ROWS)
					a.dots = cells[r.row * bdp_pkg::STORE_COLS + r.col];
			default: ;
		endcase
		return a;
	endfunction

	// --- request and register drivers --------------------------------------
	task automatic send_request(request_t r);
		answer_t a;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.cmd;
		s_tdata  <= {5'b0, 6'(r.row), 7'(r.col), 9'(r.ry), 9'(r.rx),
			11'(r.yb), 11'(r.xb), 11'(r.ya), 11'(r.xa)};
		do @(posedge clk); while (!s_tready);
		a = canvas_apply(r);
		// typed-in answers override the model, which still tracks the canvas
		if (r.known) begin
			a.dots = r.dots;
			a.status = r.status;
		end
		pending.push_back(a);
	endtask

	task automatic write_reg(logic [1:0] index, logic [8:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == bdp_pkg::CFG_WIDTH)
			reg_width = value;
		else
			reg_height = value;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// --- random requests ----------------------------------------------------
	function automatic int any_coord();
		return int'($urandom_range(2047)) - 1024;
	endfunction

	function automatic int near_coord(int span);
		return ($urandom_range(19) == 0) ? any_coord() : int'($urandom_range(span + 15)) - 8;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       pick;
		r.known = 1'b0;
		r.dots = '0;
		r.status = 1'b0;
		r.xa = near_coord(canvas_w());
		r.ya = near_coord(canvas_h());
		r.xb = near_coord(canvas_w());
		r.yb = near_coord(canvas_h());
		r.rx = $urandom_range(15);
		r.ry = $urandom_range(15);
		r.col = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(canvas_w() / 2);
		r.row = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(canvas_h() / 4);
		if (r.col > 127) r.col = 127;
		if (r.row > 63) r.row = 63;
		pick = $urandom_range(99);
		if (pick < 14)      r.cmd = bdp_pkg::CMD_DOT_ON;
		else if (pick < 22) r.cmd = bdp_pkg::CMD_DOT_OFF;
		else if (pick < 30) r.cmd = bdp_pkg::CMD_TOGGLE;
		else if (pick < 46) r.cmd = bdp_pkg::CMD_LINE;
		else if (pick < 56) r.cmd = bdp_pkg::CMD_ELLIPSE;
		else if (pick < 64) r.cmd = bdp_pkg::CMD_FILLED;
		else if (pick < 97) r.cmd = bdp_pkg::CMD_READ;
		else                r.cmd = bdp_pkg::CMD_NOP;
		// full-range radii only on outlines; a big filled shape costs too much
		if (r.cmd == bdp_pkg::CMD_ELLIPSE && $urandom_range(24) == 0) begin
			r.rx = $urandom_range(511);
			r.ry = $urandom_range(511);
		end
		if (r.cmd == bdp_pkg::CMD_FILLED && $urandom_range(29) == 0) begin
			r.rx = $urandom_range(40);
			r.ry = $urandom_range(40);
		end
		return r;
	endfunction

	// --- result checking ----------------------------------------------------
	task automatic report(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		answer_t a;
		if (m_tvalid && m_tready) begin
			if (pending.size() == 0)
				report("unexpected result, cell_dots", m_tdata, 0);
			else begin
				a = pending.pop_front();
				if (m_tdata !== a.dots)
					report("cell_dots", m_tdata, a.dots);
				if (m_tuser[0] !== a.status)
					report("status", m_tuser[0], a.status);
			end
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= snk_stall);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** braille_dot_plot_engine: FAILED **");
			$finish;
		end
	end

	// --- directed table -----------------------------------------------------
	request_t directed [] = '{
		'{bdp_pkg::CMD_READ,      0,     0,    0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_READ,      0,     0,    0,     0,   0,   0, 127, 63, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_DOT_ON,    0,     0,    0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_DOT_ON,    1,     3,    0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_DOT_ON,  255,   255,    0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_READ,      0,     0,    0,     0,   0,   0,   0,  0, 1, 8'h81, 1'b0},
		'{bdp_pkg::CMD_READ,      0,     0,    0,     0,   0,   0, 127, 63, 1, 8'h80, 1'b0},
		'{bdp_pkg::CMD_TOGGLE,    0,     0,    0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_READ,      0,     0,    0,     0,   0,   0,   0,  0, 1, 8'h80, 1'b0},
		'{bdp_pkg::CMD_DOT_OFF,   1,     3,    0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_READ,      0,     0,    0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_DOT_ON, -1024,  1023,   0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_DOT_ON,  256,     0,    0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		// both ends off the canvas
		'{bdp_pkg::CMD_LINE, -1024, -1024, 1023,  1023,   0,   0,   0,  0, 1, 8'h00, 1'b1},
		'{bdp_pkg::CMD_LINE,     0,    10,   40,    30,   0,   0,   0,  0, 0, 8'h00, 1'b0},
		'{bdp_pkg::CMD_LINE,   200,   200, 1023, -1024,   0,   0,   0,  0, 0, 8'h00, 1'b0},
		'{bdp_pkg::CMD_LINE,     5,     5,    5,     5,   0,   0,   0,  0, 0, 8'h00, 1'b0},
		'{bdp_pkg::CMD_ELLIPSE, 60,    30,    0,     0,  20,  10,   0,  0, 0, 8'h00, 1'b0},
		'{bdp_pkg::CMD_ELLIPSE, 128,  128,    0,     0, 511, 511,   0,  0, 0, 8'h00, 1'b0},
		'{bdp_pkg::CMD_ELLIPSE, 10,    10,    0,     0,   0,   0,   0,  0, 0, 8'h00, 1'b0},
		'{bdp_pkg::CMD_FILLED, 100,    40,    0,     0,  12,   7,   0,  0, 0, 8'h00, 1'b0},
		'{bdp_pkg::CMD_FILLED,   3,     3,    0,     0,   0,   5,   0,  0, 0, 8'h00, 1'b0},
		'{bdp_pkg::CMD_NOP,      0,     0,    0,     0,   0,   0,   0,  0, 1, 8'h00, 1'b0},
		'{bdp_pkg::CMD_READ,     0,     0,    0,     0,   0,   0,  30,  7, 0, 8'h00, 1'b0},
		'{bdp_pkg::CMD_READ,     0,     0,    0,     0,   0,   0,  50, 10, 0, 8'h00, 1'b0}
	};

	// canvas settings per random phase, extremes and saturation included
	int phase_w [RAND_PHASES] = '{256, 2, 511, 37, 0, 256};
	int phase_h [RAND_PHASES] = '{256, 4, 511, 90, 9, 256};

	initial begin
		foreach (cells[i])
			cells[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(bdp_pkg::CFG_WIDTH, 9'd256);
		write_reg(bdp_pkg::CFG_HEIGHT, 9'd256);
		foreach (directed[i])
			send_request(directed[i]);
		drain();
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_reg(bdp_pkg::CFG_WIDTH, 9'(phase_w[p]));
			write_reg(bdp_pkg::CFG_HEIGHT, 9'(phase_h[p]));
			// idling pattern rotates: none, sender, receiver, both
			case (p % 4)
				0: begin src_idle = 0;  snk_stall = 0;  end
				1: begin src_idle = 57; snk_stall = 0;  end
				2: begin src_idle = 0;  snk_stall = 57; end
				default: begin src_idle = 8; snk_stall = 8; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request());
			drain();
		end
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("** braille_dot_plot_engine: PASSED **");
		else
			$display("** braille_dot_plot_engine: FAILED **");
		$finish;
	end

endmodule
